/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the pool and queue manager.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/ppqtm_pkg.sv */
// Package of the pool and queue manager: sizes, link encoding, row layout,
// command codes and sequencer codes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ppqtm_pkg;
  localparam int POOL_SIZE = 32;
  localparam int IDX_W     = $clog2(POOL_SIZE);
  localparam int LINK_W    = IDX_W + 1;
  localparam int CNT_W     = IDX_W + 1;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 16;

  // A link is an entry number with an extra top bit that marks it absent.
  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(1) << IDX_W;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  typedef struct packed {
    link_t nx;
    link_t pv;
    link_t ch;
    link_t pa;
    link_t ns;
    link_t ps;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic [3:0] {
    OP_ALLOC     = 4'd0,
    OP_FREE      = 4'd1,
    OP_ENQUEUE   = 4'd2,
    OP_DEQUEUE   = 4'd3,
    OP_REMOVE    = 4'd4,
    OP_HEAD      = 4'd5,
    OP_ADD_CHILD = 4'd6,
    OP_TAKE_CHILD= 4'd7,
    OP_DETACH    = 4'd8,
    OP_HAS_CHILD = 4'd9
  } op_t;

  typedef enum logic [5:0] {
    FSM_IDLE  = 6'b000001,
    FSM_CLEAR = 6'b000010,
    FSM_START = 6'b000100,
    FSM_RD    = 6'b001000,
    FSM_EX    = 6'b010000,
    FSM_OUT   = 6'b100000
  } fsm_t;

  typedef enum logic [5:0] {
    S_ALLOC      = 6'd0,
    S_FREE       = 6'd1,
    S_ENQ_SINGLE = 6'd2,
    S_ENQ_T0     = 6'd3,
    S_ENQ_P      = 6'd4,
    S_ENQ_T1     = 6'd5,
    S_ENQ_H      = 6'd6,
    S_DEQ_T      = 6'd7,
    S_TH_H       = 6'd8,
    S_TH_NN      = 6'd9,
    S_TH_T       = 6'd10,
    S_REM_T      = 6'd11,
    S_REM_PV     = 6'd12,
    S_REM_HPV    = 6'd13,
    S_REM_H      = 6'd14,
    S_REM_WALK   = 6'd15,
    S_REM_LPV    = 6'd16,
    S_REM_LNX    = 6'd17,
    S_HEAD       = 6'd18,
    S_ADD_PAR0   = 6'd19,
    S_ADD_P      = 6'd20,
    S_ADD_OLD    = 6'd21,
    S_ADD_PAR1   = 6'd22,
    S_TFC_PAR0   = 6'd23,
    S_TFC_C0     = 6'd24,
    S_TFC_PAR1   = 6'd25,
    S_TFC_NX     = 6'd26,
    S_TFC_C1     = 6'd27,
    S_DET_P      = 6'd28,
    S_DET_PP     = 6'd29,
    S_DET_PV     = 6'd30,
    S_DET_NX     = 6'd31,
    S_DET_P1     = 6'd32,
    S_FIN        = 6'd33
  } step_t;

  function automatic logic present(input link_t lk);
    present = !lk[IDX_W];
  endfunction

  function automatic link_t to_link(input idx_t i);
    to_link = {1'b0, i};
  endfunction
endpackage
`default_nettype wire

/* src/process_pool_queue_tree_manager.sv */
// Top level of the descriptor pool, queue and tree manager.
// Depends on ppqtm_pkg, ppqtm_ram and assert_macros.svh.
//
// Use: one command beat enters on the s_ channel and exactly one result
// beat leaves on the m_ channel. The caller holds the tail of each queue
// and sends it with every queue command; the new tail comes back in the
// result. All six link tables live in one row-wide RAM with a single port.
// After reset a clearing pass writes the initial links, one row a cycle,
// for all POOL_SIZE rows (32); s_tready stays low meanwhile.
// A sequencer does each read-modify-write of a row as an address step, then
// a data and write-back step, and ends with a final row read for the child
// flag. Named removal walks the queue entry by entry.
// Only one command is in flight: s_tready is high only when idle. The
// result is held in an output register until m_tready takes it; a stalled
// receiver holds the block, nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module process_pool_queue_tree_manager
  import ppqtm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // operation[3:0], tail_index[8:4], tail_present[9], node_index[14:10],
  // parent_index[19:15], zero fill [23:20]
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // entry_out[4:0], entry_present[5], new_tail[10:6], new_tail_present[11],
  // has_child[12], zero fill [15:13]
  output logic      [OUT_W-1:0] m_tdata
);
  fsm_t  fsm, fsm_next;
  step_t step, step_next;
  idx_t  addr, addr_next;
  idx_t  clr_cnt;
  op_t   op;
  idx_t  t, t_next, p, par, par_w, par_w_next;
  logic  tp, tp_next;
  link_t e, e_next, h, h_next, nn, nn_next, a, a_next, b, b_next;
  link_t cur, cur_next, fh, fh_next;
  logic [CNT_W-1:0] steps, steps_next;
  logic  hc, hc_next;

  logic  ram_we;
  idx_t  ram_addr;
  row_t  r, w, clr_row;
  logic [ROW_W-1:0] ram_rdata;

  assign r = row_t'(ram_rdata);

  ppqtm_ram #(.WIDTH(ROW_W), .DEPTH(POOL_SIZE)) u_links (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_we && fsm == FSM_CLEAR ? clr_row : w),
    .rdata (ram_rdata)
  );

  always_comb begin
    clr_row    = '{LINK_NONE, LINK_NONE, LINK_NONE, LINK_NONE, LINK_NONE, LINK_NONE};
    clr_row.nx = (clr_cnt == '0) ? LINK_NONE : to_link(clr_cnt - idx_t'(1));
  end

  assign s_tready = (fsm == FSM_IDLE);
  assign m_tvalid = (fsm == FSM_OUT);
  assign m_tdata  = {3'b000, hc, tp, (tp ? t : idx_t'(0)), present(e),
                     (present(e) ? e[IDX_W-1:0] : idx_t'(0))};

  always_comb begin
    fsm_next   = fsm;
    step_next  = step;
    addr_next  = addr;
    t_next     = t;
    tp_next    = tp;
    par_w_next = par_w;
    e_next     = e;
    h_next     = h;
    nn_next    = nn;
    a_next     = a;
    b_next     = b;
    cur_next   = cur;
    fh_next    = fh;
    steps_next = steps;
    hc_next    = hc;
    w          = r;
    ram_we     = 1'b0;
    ram_addr   = addr;
    case (fsm)
      FSM_IDLE: begin
        if (s_tvalid) begin
          fsm_next = FSM_START;
        end
      end
      FSM_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
        if (clr_cnt == idx_t'(POOL_SIZE - 1)) begin
          fsm_next = FSM_IDLE;
        end
      end
      FSM_START: begin
        fsm_next  = FSM_RD;
        addr_next = par;
        step_next = S_FIN;
        case (op)
          OP_ALLOC: begin
            if (present(fh)) begin
              addr_next = fh[IDX_W-1:0];
              step_next = S_ALLOC;
            end
          end
          OP_FREE: begin
            addr_next = p;
            step_next = S_FREE;
          end
          OP_ENQUEUE: begin
            addr_next = tp ? t : p;
            step_next = tp ? S_ENQ_T0 : S_ENQ_SINGLE;
          end
          OP_DEQUEUE, OP_REMOVE, OP_HEAD: begin
            if (tp) begin
              addr_next = t;
              step_next = (op == OP_DEQUEUE) ? S_DEQ_T :
                          (op == OP_REMOVE)  ? S_REM_T : S_HEAD;
            end
          end
          OP_ADD_CHILD: begin
            step_next = S_ADD_PAR0;
          end
          OP_TAKE_CHILD: begin
            step_next = S_TFC_PAR0;
          end
          OP_DETACH: begin
            addr_next = p;
            step_next = S_DET_P;
          end
          default: ;
        endcase
      end
      FSM_RD: begin
        fsm_next = FSM_EX;
      end
      FSM_EX: begin
        // Unless a step says otherwise, it ends the command.
        fsm_next  = FSM_RD;
        addr_next = par;
        step_next = S_FIN;
        case (step)
          S_ALLOC: begin
            e_next  = fh;
            fh_next = r.nx;
            w       = '{LINK_NONE, LINK_NONE, LINK_NONE, LINK_NONE, LINK_NONE, LINK_NONE};
            ram_we  = 1'b1;
          end
          S_FREE: begin
            w.nx    = fh;
            ram_we  = 1'b1;
            fh_next = to_link(p);
          end
          S_ENQ_SINGLE: begin
            w.nx    = to_link(p);
            w.pv    = to_link(p);
            ram_we  = 1'b1;
            t_next  = p;
            tp_next = 1'b1;
          end
          S_ENQ_T0: begin
            h_next    = r.nx;
            addr_next = p;
            step_next = S_ENQ_P;
          end
          S_ENQ_P: begin
            w.nx      = h;
            w.pv      = to_link(t);
            ram_we    = 1'b1;
            addr_next = t;
            step_next = S_ENQ_T1;
          end
          S_ENQ_T1: begin
            w.nx    = to_link(p);
            ram_we  = 1'b1;
            t_next  = p;
            tp_next = 1'b1;
            if (present(h)) begin
              addr_next = h[IDX_W-1:0];
              step_next = S_ENQ_H;
            end
          end
          S_ENQ_H: begin
            w.pv   = to_link(p);
            ram_we = 1'b1;
          end
          S_DEQ_T: begin
            h_next = r.nx;
            if (present(r.nx)) begin
              if (r.nx[IDX_W-1:0] == t) begin
                tp_next = 1'b0;
                e_next  = r.nx;
              end else begin
                addr_next = r.nx[IDX_W-1:0];
                step_next = S_TH_H;
              end
            end
          end
          S_TH_H: begin
            nn_next = r.nx;
            if (present(r.nx)) begin
              addr_next = r.nx[IDX_W-1:0];
              step_next = S_TH_NN;
            end
          end
          S_TH_NN: begin
            w.pv      = to_link(t);
            ram_we    = 1'b1;
            addr_next = t;
            step_next = S_TH_T;
          end
          S_TH_T: begin
            w.nx   = nn;
            ram_we = 1'b1;
            e_next = h;
          end
          S_REM_T: begin
            h_next = r.nx;
            a_next = r.pv;
            if (present(r.nx)) begin
              if (r.nx[IDX_W-1:0] == t) begin
                if (t == p) begin
                  e_next  = to_link(p);
                  tp_next = 1'b0;
                end
              end else if (r.nx[IDX_W-1:0] == p) begin
                addr_next = p;
                step_next = S_TH_H;
              end else if (t == p) begin
                if (present(r.pv)) begin
                  addr_next = r.pv[IDX_W-1:0];
                  step_next = S_REM_PV;
                end
              end else begin
                addr_next = r.nx[IDX_W-1:0];
                step_next = S_REM_H;
              end
            end
          end
          S_REM_PV: begin
            w.nx      = h;
            ram_we    = 1'b1;
            addr_next = h[IDX_W-1:0];
            step_next = S_REM_HPV;
          end
          S_REM_HPV: begin
            w.pv   = a;
            ram_we = 1'b1;
            t_next = a[IDX_W-1:0];
            e_next = to_link(p);
          end
          S_REM_H, S_REM_WALK: begin
            if (step == S_REM_WALK && cur[IDX_W-1:0] == p) begin
              a_next = r.pv;
              b_next = r.nx;
              e_next = cur;
              if (present(r.pv)) begin
                addr_next = r.pv[IDX_W-1:0];
                step_next = S_REM_LPV;
              end else if (present(r.nx)) begin
                addr_next = r.nx[IDX_W-1:0];
                step_next = S_REM_LNX;
              end
            end else begin
              cur_next   = r.nx;
              steps_next = (step == S_REM_H) ? '0 : steps + CNT_W'(1);
              if (steps_next < CNT_W'(POOL_SIZE) && present(r.nx) &&
                  r.nx[IDX_W-1:0] != t) begin
                addr_next = r.nx[IDX_W-1:0];
                step_next = S_REM_WALK;
              end
            end
          end
          S_REM_LPV: begin
            w.nx   = b;
            ram_we = 1'b1;
            if (present(b)) begin
              addr_next = b[IDX_W-1:0];
              step_next = S_REM_LNX;
            end
          end
          S_REM_LNX: begin
            w.pv   = a;
            ram_we = 1'b1;
          end
          S_HEAD: begin
            e_next = r.nx;
          end
          S_ADD_PAR0: begin
            h_next    = r.ch;
            addr_next = p;
            step_next = S_ADD_P;
          end
          S_ADD_P: begin
            w.pa      = to_link(par);
            w.ps      = LINK_NONE;
            w.ns      = h;
            ram_we    = 1'b1;
            addr_next = present(h) ? h[IDX_W-1:0] : par;
            step_next = present(h) ? S_ADD_OLD : S_ADD_PAR1;
          end
          S_ADD_OLD: begin
            w.ps      = to_link(p);
            ram_we    = 1'b1;
            step_next = S_ADD_PAR1;
          end
          S_ADD_PAR1: begin
            w.ch   = to_link(p);
            ram_we = 1'b1;
          end
          S_TFC_PAR0: begin
            h_next = r.ch;
            if (present(r.ch)) begin
              addr_next = r.ch[IDX_W-1:0];
              step_next = S_TFC_C0;
            end
          end
          S_TFC_C0: begin
            nn_next   = r.ns;
            addr_next = par_w;
            step_next = S_TFC_PAR1;
          end
          S_TFC_PAR1: begin
            w.ch      = nn;
            ram_we    = 1'b1;
            addr_next = present(nn) ? nn[IDX_W-1:0] : h[IDX_W-1:0];
            step_next = present(nn) ? S_TFC_NX : S_TFC_C1;
          end
          S_TFC_NX: begin
            w.ps      = LINK_NONE;
            ram_we    = 1'b1;
            addr_next = h[IDX_W-1:0];
            step_next = S_TFC_C1;
          end
          S_TFC_C1: begin
            w.pa   = LINK_NONE;
            w.ns   = LINK_NONE;
            w.ps   = LINK_NONE;
            ram_we = 1'b1;
            e_next = h;
          end
          S_DET_P: begin
            h_next = r.pa;
            a_next = r.ps;
            b_next = r.ns;
            if (present(r.pa)) begin
              addr_next = r.pa[IDX_W-1:0];
              step_next = S_DET_PP;
            end
          end
          S_DET_PP: begin
            if (r.ch == to_link(p)) begin
              // The node is the first child: unlink it as a child removal.
              par_w_next = h[IDX_W-1:0];
              h_next     = to_link(p);
              addr_next  = p;
              step_next  = S_TFC_C0;
            end else if (present(a)) begin
              addr_next = a[IDX_W-1:0];
              step_next = S_DET_PV;
            end else begin
              addr_next = present(b) ? b[IDX_W-1:0] : p;
              step_next = present(b) ? S_DET_NX : S_DET_P1;
            end
          end
          S_DET_PV: begin
            w.ns      = b;
            ram_we    = 1'b1;
            addr_next = present(b) ? b[IDX_W-1:0] : p;
            step_next = present(b) ? S_DET_NX : S_DET_P1;
          end
          S_DET_NX: begin
            w.ps      = a;
            ram_we    = 1'b1;
            addr_next = p;
            step_next = S_DET_P1;
          end
          S_DET_P1: begin
            w.pa   = LINK_NONE;
            w.ns   = LINK_NONE;
            w.ps   = LINK_NONE;
            ram_we = 1'b1;
            e_next = to_link(p);
          end
          S_FIN: begin
            hc_next  = present(r.ch);
            fsm_next = FSM_OUT;
          end
          default: begin
            fsm_next = FSM_OUT;
          end
        endcase
      end
      FSM_OUT: begin
        if (m_tready) begin
          fsm_next = FSM_IDLE;
        end
      end
      default: begin
        fsm_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm     <= FSM_CLEAR;
      clr_cnt <= '0;
      fh      <= to_link(idx_t'(POOL_SIZE - 1));
      step    <= S_FIN;
    end else begin
      fsm  <= fsm_next;
      step <= step_next;
      fh   <= fh_next;
      if (fsm == FSM_CLEAR) begin
        clr_cnt <= clr_cnt + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    addr  <= addr_next;
    h     <= h_next;
    nn    <= nn_next;
    a     <= a_next;
    b     <= b_next;
    cur   <= cur_next;
    steps <= steps_next;
    hc    <= hc_next;
    if (s_tvalid && s_tready) begin
      op    <= op_t'(s_tdata[3:0]);
      t     <= s_tdata[8:4];
      tp    <= s_tdata[9];
      p     <= s_tdata[14:10];
      par   <= s_tdata[19:15];
      par_w <= s_tdata[19:15];
      e     <= LINK_NONE;
    end else begin
      t     <= t_next;
      tp    <= tp_next;
      par_w <= par_w_next;
      e     <= e_next;
    end
  end

  `ASSERT_IMPL(a_no_write_idle, clk, rst, fsm == FSM_IDLE || fsm == FSM_OUT, !ram_we)
  `ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, fsm == FSM_START)
  `ASSERT_NEXT(a_out_holds, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
`default_nettype wire

/* src/ppqtm_ram.sv */
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module ppqtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the descriptor pool, queue and tree manager.
// Depends on ppqtm_pkg and process_pool_queue_tree_manager.
// The testbench runs a directed table and then mostly well-formed random
// command sequences, and checks every result beat against its own model or a fixed expectation.
`timescale 1ns / 1ps
module tb_top;
  import ppqtm_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 300;
  localparam int N_QUEUES       = 4;

  typedef struct {
    logic [3:0] op;
    logic [4:0] tail;
    logic       tail_p;
    logic [4:0] node;
    logic [4:0] par;
  } cmd_t;

  typedef struct packed {
    logic [4:0] e;
    logic       ep;
    logic [4:0] nt;
    logic       ntp;
    logic       hc;
  } result_t;

  typedef struct {
    cmd_t    c;
    logic    use_q0;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  process_pool_queue_tree_manager dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Link tables of the model; bit 5 set means the link is absent.
  link_t nx_tab [POOL_SIZE];
  link_t pv_tab [POOL_SIZE];
  link_t ch_tab [POOL_SIZE];
  link_t pa_tab [POOL_SIZE];
  link_t ns_tab [POOL_SIZE];
  link_t ps_tab [POOL_SIZE];
  link_t free_top;

  result_t pending_results [$];
  int      spare_q [$];
  int      loose_q [$];
  logic [4:0] q_tail [N_QUEUES];
  logic       q_live [N_QUEUES];

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_hits = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic linked(input link_t lk);
    return !lk[IDX_W];
  endfunction

  function automatic link_t lk(input logic [4:0] i);
    return {1'b0, i};
  endfunction

  task automatic reset_model();
    for (int i = 0; i < POOL_SIZE; i++) begin
      nx_tab[i] = (i == 0) ? LINK_NONE : link_t'(i - 1);
      pv_tab[i] = LINK_NONE;
      ch_tab[i] = LINK_NONE;
      pa_tab[i] = LINK_NONE;
      ns_tab[i] = LINK_NONE;
      ps_tab[i] = LINK_NONE;
    end
    free_top = link_t'(POOL_SIZE - 1);
  endtask

  // Takes the head off a non-empty queue; emptied is set when it was alone.
  function automatic link_t pop_head(inout logic [4:0] t, output logic emptied);
    link_t h;
    link_t nn;
    emptied = 1'b0;
    h = nx_tab[t];
    if (!linked(h)) return LINK_NONE;
    if (h == lk(t)) begin
      emptied = 1'b1;
      return h;
    end
    nn = nx_tab[h[4:0]];
    if (!linked(nn)) return LINK_NONE;
    pv_tab[nn[4:0]] = lk(t);
    nx_tab[t] = nn;
    return h;
  endfunction

  function automatic link_t pop_child(input logic [4:0] par);
    link_t c;
    link_t nx;
    c = ch_tab[par];
    if (!linked(c)) return LINK_NONE;
    nx = ns_tab[c[4:0]];
    ch_tab[par] = nx;
    if (linked(nx)) ps_tab[nx[4:0]] = LINK_NONE;
    pa_tab[c[4:0]] = LINK_NONE;
    ns_tab[c[4:0]] = LINK_NONE;
    ps_tab[c[4:0]] = LINK_NONE;
    return c;
  endfunction

  function automatic result_t predict_cmd(input cmd_t c);
    result_t r;
    link_t e;
    link_t h;
    link_t cur;
    link_t pv;
    link_t nx;
    link_t old;
    link_t pp;
    logic [4:0] t;
    logic tp;
    logic emptied;
    logic done;
    logic [4:0] p;
    logic [4:0] par;
    e = LINK_NONE;
    t = c.tail;
    tp = c.tail_p;
    p = c.node;
    par = c.par;
    emptied = 1'b0;
    case (c.op)
      OP_ALLOC: begin
        e = free_top;
        if (linked(e)) begin
          free_top = nx_tab[e[4:0]];
          nx_tab[e[4:0]] = LINK_NONE;
          pv_tab[e[4:0]] = LINK_NONE;
          ch_tab[e[4:0]] = LINK_NONE;
          pa_tab[e[4:0]] = LINK_NONE;
          ns_tab[e[4:0]] = LINK_NONE;
          ps_tab[e[4:0]] = LINK_NONE;
        end
      end
      OP_FREE: begin
        nx_tab[p] = free_top;
        free_top = lk(p);
      end
      OP_ENQUEUE: begin
        if (!tp) begin
          nx_tab[p] = lk(p);
          pv_tab[p] = lk(p);
        end else begin
          h = nx_tab[t];
          nx_tab[p] = h;
          nx_tab[t] = lk(p);
          pv_tab[p] = lk(t);
          if (linked(h)) pv_tab[h[4:0]] = lk(p);
        end
        t = p;
        tp = 1'b1;
      end
      OP_DEQUEUE: begin
        if (tp) begin
          e = pop_head(t, emptied);
          if (emptied) tp = 1'b0;
        end
      end
      OP_REMOVE: begin
        if (tp) begin
          h = nx_tab[t];
          if (linked(h)) begin
            if (h == lk(t)) begin
              // Only element: the queue becomes empty if it is the named node.
              if (t == p) begin
                e = lk(p);
                tp = 1'b0;
              end
            end else if (h == lk(p)) begin
              e = pop_head(t, emptied);
              if (emptied) tp = 1'b0;
            end else if (t == p) begin
              pv = pv_tab[t];
              if (linked(pv)) begin
                nx_tab[pv[4:0]] = h;
                pv_tab[h[4:0]] = pv;
                t = pv[4:0];
                e = lk(p);
              end
            end else begin
              cur = nx_tab[h[4:0]];
              done = 1'b0;
              for (int k = 0; k < POOL_SIZE && !done && linked(cur) && cur != lk(t); k++) begin
                if (cur == lk(p)) begin
                  pv = pv_tab[cur[4:0]];
                  nx = nx_tab[cur[4:0]];
                  if (linked(pv)) nx_tab[pv[4:0]] = nx;
                  if (linked(nx)) pv_tab[nx[4:0]] = pv;
                  e = cur;
                  done = 1'b1;
                end else begin
                  cur = nx_tab[cur[4:0]];
                end
              end
            end
          end
        end
      end
      OP_HEAD: begin
        if (tp) e = nx_tab[t];
      end
      OP_ADD_CHILD: begin
        old = ch_tab[par];
        pa_tab[p] = lk(par);
        ps_tab[p] = LINK_NONE;
        ns_tab[p] = old;
        if (linked(old)) ps_tab[old[4:0]] = lk(p);
        ch_tab[par] = lk(p);
      end
      OP_TAKE_CHILD: e = pop_child(par);
      OP_DETACH: begin
        pp = pa_tab[p];
        if (linked(pp)) begin
          if (ch_tab[pp[4:0]] == lk(p)) begin
            e = pop_child(pp[4:0]);
          end else begin
            // Middle or last child: unlink it between its neighbors.
            pv = ps_tab[p];
            nx = ns_tab[p];
            if (linked(pv)) ns_tab[pv[4:0]] = nx;
            if (linked(nx)) ps_tab[nx[4:0]] = pv;
            ns_tab[p] = LINK_NONE;
            ps_tab[p] = LINK_NONE;
            pa_tab[p] = LINK_NONE;
            e = lk(p);
          end
        end
      end
      default: ;
    endcase
    r.e = linked(e) ? e[4:0] : 5'd0;
    r.ep = linked(e);
    r.nt = tp ? t : 5'd0;
    r.ntp = tp;
    r.hc = linked(ch_tab[par]);
    return r;
  endfunction

  // Offers one command beat, holds it until accepted, then predicts it.
  task automatic drive_cmd(input cmd_t c, input logic typed, input result_t want,
                           output result_t got);
    s_tvalid <= 1'b1;
    s_tdata <= {4'd0, c.par, c.node, c.tail_p, c.tail, c.op};
    do @(posedge clk); while (!s_tready);
    got = predict_cmd(c);
    pending_results.push_back(typed ? want : got);
    n_sent++;
    if ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic int take_from(inout int lst[$]);
    int v;
    int idx;
    if (lst.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, POOL_SIZE - 1);
    idx = $urandom_range(0, lst.size() - 1);
    v = lst[idx];
    lst[idx] = lst[lst.size() - 1];
    void'(lst.pop_back());
    return v;
  endfunction

  task automatic run_random(input int count);
    cmd_t c;
    result_t r;
    result_t none;
    int q;
    int sel;
    none = '{default: '0};
    for (int n = 0; n < count; n++) begin
      q = $urandom_range(0, N_QUEUES - 1);
      sel = $urandom_range(0, 99);
      c.tail = q_tail[q];
      c.tail_p = q_live[q];
      c.node = 5'($urandom_range(0, POOL_SIZE - 1));
      c.par = 5'($urandom_range(0, 7));
      if (sel < 12) c.op = OP_ALLOC;
      else if (sel < 20) begin
        c.op = OP_FREE;
        c.node = 5'(take_from(loose_q));
      end else if (sel < 38) begin
        c.op = OP_ENQUEUE;
        c.node = 5'(take_from(spare_q));
      end else if (sel < 50) c.op = OP_DEQUEUE;
      else if (sel < 58) c.op = OP_REMOVE;
      else if (sel < 64) c.op = OP_HEAD;
      else if (sel < 74) begin
        c.op = OP_ADD_CHILD;
        c.node = 5'(take_from(loose_q));
      end else if (sel < 81) c.op = OP_TAKE_CHILD;
      else if (sel < 87) c.op = OP_DETACH;
      else if (sel < 91) c.op = OP_HAS_CHILD;
      else begin
        // Noise: any field value, unused codes and stale tails included.
        c.op = 4'($urandom_range(0, 15));
        c.tail = 5'($urandom_range(0, 31));
        c.tail_p = 1'($urandom_range(0, 1));
        c.par = 5'($urandom_range(0, 31));
        q = -1;
      end
      drive_cmd(c, 1'b0, none, r);
      if (q >= 0) begin
        q_tail[q] = r.nt;
        q_live[q] = r.ntp;
      end
      if (r.ep && c.op == OP_ALLOC) spare_q.push_back(r.e);
      else if (r.ep && c.op != OP_HEAD) loose_q.push_back(r.e);
      if (n % 50 == 25 && $urandom_range(0, 3) == 0) begin
        // Occasionally redraw the parent field after the command has been sent.
        c.par = 5'($urandom_range(0, 31));
      end
    end
  endtask

  // Result monitor, receiver stalls and the long hold-off.
  initial begin
    int hold_left;
    result_t act;
    result_t want;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        act.e = m_tdata[4:0];
        act.ep = m_tdata[5];
        act.nt = m_tdata[10:6];
        act.ntp = m_tdata[11];
        act.hc = m_tdata[12];
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("result beat with nothing expected: %h", m_tdata);
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (act.ep) n_hits++;
          if (act != want) begin
            n_errors++;
            if (n_errors <= 10)
              $display("beat %0d mismatch: exp e=%0d/%0b tail=%0d/%0b hc=%0b, got e=%0d/%0b tail=%0d/%0b hc=%0b",
                       n_checked, want.e, want.ep, want.nt, want.ntp, want.hc,
                       act.e, act.ep, act.nt, act.ntp, act.hc);
          end
        end
      end
      if (hold_req != 0) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_top failed");
    $finish;
  end

  initial begin
    dir_row_t tab [$];
    dir_row_t row;
    result_t r;
    cmd_t c;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    reset_model();
    for (int i = 0; i < N_QUEUES; i++) begin
      q_tail[i] = '0;
      q_live[i] = 1'b0;
    end

    row = '{default: '0};
    row.c = '{OP_ALLOC, 0, 0, 0, 20};
    row.typed = 1'b1;
    row.want = '{31, 1, 0, 0, 0};
    tab.push_back(row);
    row = '{default: '0};
    row.c = '{OP_ALLOC, 0, 0, 0, 20};
    repeat (3) tab.push_back(row);
    row.use_q0 = 1'b1;
    for (int i = 31; i >= 28; i--) begin
      row.c = '{OP_ENQUEUE, 0, 0, 5'(i), 20};
      tab.push_back(row);
    end
    row.c = '{OP_HEAD, 0, 0, 0, 20};   tab.push_back(row);
    row.c = '{OP_REMOVE, 0, 0, 30, 20}; tab.push_back(row);
    row.c = '{OP_REMOVE, 0, 0, 28, 20}; tab.push_back(row);
    row.c = '{OP_REMOVE, 0, 0, 31, 20}; tab.push_back(row);
    row.c = '{OP_DEQUEUE, 0, 0, 0, 20}; tab.push_back(row);
    row.c = '{OP_REMOVE, 0, 0, 29, 20}; tab.push_back(row);
    row.c = '{OP_ENQUEUE, 0, 0, 29, 20}; tab.push_back(row);
    row.c = '{OP_REMOVE, 0, 0, 29, 20}; tab.push_back(row);
    row.use_q0 = 1'b0;
    row.c = '{OP_DEQUEUE, 0, 0, 0, 20};
    row.typed = 1'b1;
    row.want = '{0, 0, 0, 0, 0};
    tab.push_back(row);
    row.typed = 1'b0;
    row.c = '{OP_ADD_CHILD, 0, 0, 5, 0};  tab.push_back(row);
    row.c = '{OP_ADD_CHILD, 0, 0, 6, 0};  tab.push_back(row);
    row.c = '{OP_ADD_CHILD, 0, 0, 7, 0};  tab.push_back(row);
    row.c = '{OP_DETACH, 0, 0, 6, 0};     tab.push_back(row);
    row.c = '{OP_HAS_CHILD, 0, 0, 0, 0};  tab.push_back(row);
    row.c = '{OP_TAKE_CHILD, 0, 0, 0, 0}; tab.push_back(row);
    row.c = '{OP_DETACH, 0, 0, 5, 0};     tab.push_back(row);
    row.c = '{OP_FREE, 0, 0, 31, 20};     tab.push_back(row);
    row.c = '{4'd15, 31, 1, 31, 20};
    row.typed = 1'b1;
    row.want = '{0, 0, 31, 1, 0};
    tab.push_back(row);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (tab[i]) begin
      c = tab[i].c;
      if (tab[i].use_q0) begin
        c.tail = q_tail[0];
        c.tail_p = q_live[0];
      end
      drive_cmd(c, tab[i].typed, tab[i].want, r);
      if (tab[i].use_q0) begin
        q_tail[0] = r.nt;
        q_live[0] = r.ntp;
      end
    end

    // The receiver holds off while commands keep coming, so the block backs up.
    hold_req = 1;
    run_random(40);
    idle_pct = 80;  stall_pct = 0;  run_random(400);
    idle_pct = 0;   stall_pct = 80; run_random(400);
    idle_pct = 34;  stall_pct = 34; run_random(400);
    idle_pct = 0;   stall_pct = 0;  run_random(390);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d commands, checked %0d result beats (%0d carried an entry)",
             n_sent, n_checked, n_hits);
    $display("queue, free list and tree commands under four idle and stall mixes");
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("mismatches: %0d", n_errors);
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
